FILE: rtl/core/kwtl_pkg.sv
// ----------------------------------------------------------------------------
// kwtl_pkg
// Shared types, token codes, keyword table and character classes for the
// keyword token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kwtl_pkg;

  localparam int unsigned LEN_MAX_DEF = 255;
  localparam int unsigned RES_DEPTH   = 4;
  localparam int unsigned NUM_KW      = 9;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef enum logic [4:0] {
    TK_EOF    = 5'd0,
    TK_IDENT  = 5'd1,
    TK_NUMBER = 5'd2,
    TK_STRING = 5'd3,
    TK_FN     = 5'd4,
    TK_DG     = 5'd5,
    TK_VAL    = 5'd6,
    TK_VAR    = 5'd7,
    TK_SAY    = 5'd8,
    TK_DEFINE = 5'd9,
    TK_STAR   = 5'd10,
    TK_END    = 5'd11,
    TK_HEX    = 5'd12,
    TK_ASM    = 5'd13,
    TK_LPAREN = 5'd14,
    TK_RPAREN = 5'd15,
    TK_LBRACE = 5'd16,
    TK_RBRACE = 5'd17,
    TK_SEMI   = 5'd18,
    TK_COLON  = 5'd19,
    TK_COMMA  = 5'd20,
    TK_OP     = 5'd21
  } token_kind_e;

  typedef enum logic [4:0] {
    SM_IDLE  = 5'b00001,
    SM_IDENT = 5'b00010,
    SM_NUM   = 5'b00100,
    SM_STR   = 5'b01000,
    SM_HEX   = 5'b10000
  } scan_mode_e;

  // Keyword text packed first byte low, as the head register holds it.
  localparam logic [63:0] KW_WORD [NUM_KW] = '{
    64'h0000_0000_0000_6e66,  // fn
    64'h0000_0000_0000_6764,  // dg
    64'h0000_0000_006c_6176,  // val
    64'h0000_0000_0072_6176,  // var
    64'h0000_0000_0079_6173,  // say
    64'h0000_656e_6966_6564,  // define
    64'h0000_0000_7261_7473,  // star
    64'h0000_0000_0064_6e65,  // end
    64'h0000_0000_006d_7361   // asm
  };

  localparam logic [2:0] KW_LEN [NUM_KW] = '{
    3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd6, 3'd4, 3'd3, 3'd3
  };

  localparam token_kind_e KW_KIND [NUM_KW] = '{
    TK_FN, TK_DG, TK_VAL, TK_VAR, TK_SAY, TK_DEFINE, TK_STAR, TK_END, TK_ASM
  };

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  length;
    logic [63:0] head;
    logic        last;
  } token_t;

  // Up to two tokens written into the result queue in one step.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39]});
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c inside {8'h20, [8'h09:8'h0d]});
  endfunction

  function automatic token_kind_e punct_kind(input logic [7:0] c);
    token_kind_e k;
    case (c)
      8'h28:   k = TK_LPAREN;
      8'h29:   k = TK_RPAREN;
      8'h7b:   k = TK_LBRACE;
      8'h7d:   k = TK_RBRACE;
      8'h3b:   k = TK_SEMI;
      8'h3a:   k = TK_COLON;
      8'h2c:   k = TK_COMMA;
      default: k = TK_OP;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/kwtl_if.sv
// ----------------------------------------------------------------------------
// kwtl_in_if / kwtl_out_if
// Valid/ready channels for input bytes and result tokens.
// ----------------------------------------------------------------------------
`default_nettype none

interface kwtl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] char_code;

  modport source (output valid, output kind, output char_code, input ready);
  modport sink   (input valid, input kind, input char_code, output ready);
endinterface

interface kwtl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [7:0]  token_length;
  logic [63:0] text_head;
  logic        last;

  modport source (output valid, output token_kind, output token_length,
                  output text_head, output last, input ready);
  modport sink   (input valid, input token_kind, input token_length,
                  input text_head, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/keyword_token_lexer.sv
// Path: a word taken is held in the input register until the scan step fires,
//   which waits for queue room; its tokens are then written into the result queue.
// Throughput: one input word per cycle while the result queue has room; a word
//   that yields two tokens is absorbed by a four-entry result queue.
// Reset: rst_ni asynchronous, active low; clears scan state, queue pointers
//   and the input register valid bit.
// ----------------------------------------------------------------------------
// keyword_token_lexer
// Byte-serial lexer for one line: bytes in, tokens with kind, length and
// first eight text bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_token_lexer #(
  parameter int unsigned LEN_MAX = kwtl_pkg::LEN_MAX_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  kwtl_in_if.sink     in_i,
  kwtl_out_if.source  out_o
);

  // Input register: one word, reloaded whenever the scan step consumes it.
  logic       in_vld_q;
  logic       kind_q;
  logic [7:0] char_q;

  logic             space;    // queue can take a two-token step
  logic             step;     // scan step fires this cycle
  logic             in_acc;
  kwtl_pkg::push_t  push;
  kwtl_pkg::token_t res;

  assign step       = in_vld_q && space;
  // ready does not wait for the output side unless the queue is nearly full
  assign in_i.ready = !in_vld_q || step;
  assign in_acc     = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  // payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= in_i.kind;
      char_q <= in_i.char_code;
    end
  end

  // Scan state plus the per-byte classify / keyword compare.
  kwtl_scan #(
    .LEN_MAX(LEN_MAX)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .kind_i (kind_q),
    .char_i (char_q),
    .push_o (push)
  );

  // Result queue; its head is the output word.
  kwtl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (res)
  );

  assign out_o.token_kind   = res.kind;
  assign out_o.token_length = res.length;
  assign out_o.text_head    = res.head;
  assign out_o.last         = res.last;

endmodule

`default_nettype wire

FILE: rtl/core/kwtl_scan.sv
// ----------------------------------------------------------------------------
// kwtl_scan
// Scan state and one-step token logic: one word in, up to two tokens out.
// ----------------------------------------------------------------------------
`default_nettype none

module kwtl_scan #(
  parameter int unsigned LEN_MAX = kwtl_pkg::LEN_MAX_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            step_i,
  input  wire logic            kind_i,
  input  wire logic [7:0]      char_i,
  output kwtl_pkg::push_t      push_o
);

  localparam int unsigned LenW = $clog2(LEN_MAX + 1);
  localparam int unsigned RunW = (LenW > 8) ? LenW : 8;

  kwtl_pkg::scan_mode_e mode_q, mode_d;
  logic [RunW-1:0]      run_q, run_d, run_app;
  logic [63:0]          head_q, head_d, head_app;
  logic                 stop_q, stop_d;

  kwtl_pkg::token_kind_e flush_kind;
  kwtl_pkg::token_t      tok_a, tok_b;
  logic                  flush_v, b_v, cont;

  // appended run and head
  always_comb begin
    head_app = head_q;
    if (run_q < RunW'(8)) begin
      head_app[run_q[2:0]*8 +: 8] = char_i;
    end
    run_app = (run_q < RunW'(LEN_MAX)) ? run_q + RunW'(1) : run_q;
  end

  always_comb begin
    case (mode_q)
      kwtl_pkg::SM_IDENT: begin
        flush_kind = kwtl_pkg::TK_IDENT;
        for (int i = 0; i < kwtl_pkg::NUM_KW; i++) begin
          if (run_q == RunW'(kwtl_pkg::KW_LEN[i]) && head_q == kwtl_pkg::KW_WORD[i]) begin
            flush_kind = kwtl_pkg::KW_KIND[i];
          end
        end
      end
      kwtl_pkg::SM_NUM: flush_kind = kwtl_pkg::TK_NUMBER;
      kwtl_pkg::SM_STR: flush_kind = kwtl_pkg::TK_STRING;
      kwtl_pkg::SM_HEX: flush_kind = kwtl_pkg::TK_HEX;
      default:          flush_kind = kwtl_pkg::TK_EOF;
    endcase
  end

  always_comb begin
    case (mode_q)
      kwtl_pkg::SM_IDENT: cont = kwtl_pkg::is_alpha(char_i) || kwtl_pkg::is_digit(char_i);
      kwtl_pkg::SM_NUM:   cont = kwtl_pkg::is_digit(char_i);
      kwtl_pkg::SM_HEX:   cont = kwtl_pkg::is_xdigit(char_i);
      kwtl_pkg::SM_STR:   cont = (char_i != kwtl_pkg::CH_QUOTE);
      default:            cont = 1'b0;
    endcase
  end

  always_comb begin
    mode_d  = mode_q;
    run_d   = run_q;
    head_d  = head_q;
    stop_d  = stop_q;
    flush_v = 1'b0;
    b_v     = 1'b0;
    tok_b   = '{kind: kwtl_pkg::TK_EOF, length: 8'd0, head: 64'd0, last: 1'b1};

    if (kind_i) begin
      // end of line: flush, EOF, full clear
      flush_v = !stop_q && (mode_q != kwtl_pkg::SM_IDLE);
      b_v     = 1'b1;
      mode_d  = kwtl_pkg::SM_IDLE;
      run_d   = '0;
      head_d  = '0;
      stop_d  = 1'b0;
    end else if (stop_q) begin
      // rest of line ignored
    end else if (char_i == kwtl_pkg::CH_NUL) begin
      flush_v = (mode_q != kwtl_pkg::SM_IDLE);
      mode_d  = kwtl_pkg::SM_IDLE;
      run_d   = '0;
      head_d  = '0;
      stop_d  = 1'b1;
    end else if (cont) begin
      run_d  = run_app;
      head_d = head_app;
    end else if (mode_q == kwtl_pkg::SM_STR) begin
      // closing quote
      flush_v = 1'b1;
      mode_d  = kwtl_pkg::SM_IDLE;
      run_d   = '0;
      head_d  = '0;
    end else begin
      // token ends here; the byte starts a fresh scan
      flush_v = (mode_q != kwtl_pkg::SM_IDLE);
      mode_d  = kwtl_pkg::SM_IDLE;
      run_d   = '0;
      head_d  = '0;
      if (kwtl_pkg::is_space(char_i)) begin
        mode_d = kwtl_pkg::SM_IDLE;
      end else if (kwtl_pkg::is_alpha(char_i)) begin
        mode_d = kwtl_pkg::SM_IDENT;
        run_d  = RunW'(1);
        head_d = {56'd0, char_i};
      end else if (kwtl_pkg::is_digit(char_i)) begin
        mode_d = kwtl_pkg::SM_NUM;
        run_d  = RunW'(1);
        head_d = {56'd0, char_i};
      end else if (char_i == kwtl_pkg::CH_QUOTE) begin
        mode_d = kwtl_pkg::SM_STR;
      end else if (char_i == kwtl_pkg::CH_DOLLAR) begin
        mode_d = kwtl_pkg::SM_HEX;
      end else begin
        b_v   = 1'b1;
        tok_b = '{kind: kwtl_pkg::punct_kind(char_i), length: 8'd1,
                  head: {56'd0, char_i}, last: 1'b1};
      end
    end
  end

  assign tok_a = '{kind: flush_kind, length: run_q[7:0], head: head_q, last: !b_v};

  always_comb begin
    push_o.count = step_i ? ({1'b0, flush_v} + {1'b0, b_v}) : 2'd0;
    push_o.tok0  = flush_v ? tok_a : tok_b;
    push_o.tok1  = tok_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= kwtl_pkg::SM_IDLE;
      run_q  <= '0;
      head_q <= '0;
      stop_q <= 1'b0;
    end else if (step_i) begin
      mode_q <= mode_d;
      run_q  <= run_d;
      head_q <= head_d;
      stop_q <= stop_d;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kwtl_fifo.sv
// ----------------------------------------------------------------------------
// kwtl_fifo
// Result queue: takes up to two tokens a cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module kwtl_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  kwtl_pkg::push_t  push_i,
  output logic             space_o,
  output logic             valid_o,
  input  wire logic        ready_i,
  output kwtl_pkg::token_t data_o
);

  localparam int unsigned Depth = kwtl_pkg::RES_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  kwtl_pkg::token_t mem_q [Depth];
  logic [PtrW-1:0]  wp_q, rp_q;
  logic [CntW-1:0]  cnt_q;
  logic             pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  // room for a two-token word regardless of this cycle's pop
  assign space_o = (cnt_q <= CntW'(Depth - 2));

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wp_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[PtrW'(wp_q + PtrW'(1))] <= push_i.tok1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= PtrW'(wp_q + PtrW'(push_i.count));
      rp_q  <= PtrW'(rp_q + PtrW'(pop));
      cnt_q <= CntW'(cnt_q + CntW'(push_i.count) - CntW'(pop));
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/kwtl_checker.sv
// ----------------------------------------------------------------------------
// kwtl_checker
// Port-level checks on the lexer's output tokens, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kwtl_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [4:0]  token_kind_i,
  input wire logic [7:0]  token_length_i,
  input wire logic [63:0] text_head_i,
  input wire logic        last_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(token_kind_i) &&
      $stable(text_head_i) && $stable(last_i))
    else $error("output word changed while stalled");

  // EOF closes the item, with empty text
  a_eof_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i == kwtl_pkg::TK_EOF |->
      last_i && token_length_i == 8'd0 && text_head_i == 64'd0)
    else $error("malformed EOF token");

  // punctuation and operators are single bytes
  a_punct_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && token_kind_i >= kwtl_pkg::TK_LPAREN |->
      token_length_i == 8'd1 && text_head_i[63:8] == 56'd0 && last_i)
    else $error("malformed single-byte token");

  // keywords only on lengths 2 to 6, with the top two head bytes clear
  a_kw_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((token_kind_i >= kwtl_pkg::TK_FN && token_kind_i <= kwtl_pkg::TK_END) ||
      token_kind_i == kwtl_pkg::TK_ASM) |->
      token_length_i >= 8'd2 && token_length_i <= 8'd6 && text_head_i[63:48] == 16'd0)
    else $error("keyword token with bad length");

endmodule

bind keyword_token_lexer kwtl_checker u_kwtl_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .token_kind_i   (out_o.token_kind),
  .token_length_i (out_o.token_length),
  .text_head_i    (out_o.text_head),
  .last_i         (out_o.last)
);

`default_nettype wire
